### src/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// shared widths, types and register map of the segment/triangle test
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int W_CRD   = 32;   // Q16.16 coordinate
  localparam int W_TV    = 33;   // origin minus vertex
  localparam int W_XP    = 66;   // cross product component
  localparam int W_DOT   = 100;  // exact triple product
  localparam int W_EPS   = 15;   // hit epsilon
  localparam int W_DATA  = 32;   // register port data
  localparam int W_PADDR = 5;    // eight registers of four bytes

  typedef logic signed [W_CRD-1:0] crd_t;
  typedef logic signed [W_DOT-1:0] dot_t;

  typedef enum logic [2:0] {
    REG_ORG_X   = 3'd0,
    REG_ORG_Y   = 3'd1,
    REG_ORG_Z   = 3'd2,
    REG_DIR_X   = 3'd3,
    REG_DIR_Y   = 3'd4,
    REG_DIR_Z   = 3'd5,
    REG_DET_EPS = 3'd6,
    REG_HIT_EPS = 3'd7
  } reg_idx_e;

endpackage

### src/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// streaming segment versus triangle test, exact fixed point
// ----------------------------------------------------------------------------
// Tests one triangle per item against a segment held in registers (origin and
// end-minus-origin vector, signed Q16.16). The triangle arrives as vertex A
// and the edges A-to-B and A-to-C. All tests use exact integer triple
// products, so nothing rounds: a hit needs a determinant of magnitude at least
// det_epsilon (units of 2^-48), barycentric coordinates inside the closed
// triangle, and a crossing strictly between hit_epsilon and one minus
// hit_epsilon along the segment. The result is a hit flag and the crossing
// fraction, floor(t * 2^FRACTION_BITS) with its low 16 bits kept, zero on a
// miss. The pipeline takes a new item every cycle while the input is not
// stalled; it has ten arithmetic stages (products, cross products, partial
// dot products, sums, sign fix, bound checks) plus one restoring divider
// step per fraction bit, ahead of the output register. A skid stage behind
// the output register lets input be accepted while a
// result waits; input stalls only when both hold an item. Registers are
// written through the APB-style port at byte address 4*index and must only
// change while no item is in flight.
module segment_triangle_intersect #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sti_pkg::W_PADDR-1:0]  paddr,
  input  logic [sti_pkg::W_DATA-1:0]   pwdata,
  output logic [sti_pkg::W_DATA-1:0]   prdata,
  output logic                         pready,
  // triangle items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sti_pkg::crd_t                vert_a_x_i,
  input  sti_pkg::crd_t                vert_a_y_i,
  input  sti_pkg::crd_t                vert_a_z_i,
  input  sti_pkg::crd_t                edge_ab_x_i,
  input  sti_pkg::crd_t                edge_ab_y_i,
  input  sti_pkg::crd_t                edge_ab_z_i,
  input  sti_pkg::crd_t                edge_ac_x_i,
  input  sti_pkg::crd_t                edge_ac_y_i,
  input  sti_pkg::crd_t                edge_ac_z_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [15:0]                  hit_fraction_o
);
  import sti_pkg::*;

  localparam int NDIV = FRACTION_BITS;
  localparam int NS   = 10 + NDIV;                           // pipeline stages
  localparam int WS   = W_DOT + FRACTION_BITS + W_EPS + 2;   // scaled t compare

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  crd_t             org_q [3];
  crd_t             dir_q [3];
  logic [31:0]      det_eps_q;
  logic [W_EPS-1:0] hit_eps_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[W_PADDR-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        org_q[c] <= '0;
        dir_q[c] <= '0;
      end
      det_eps_q <= 32'd1;
      hit_eps_q <= W_EPS'(1);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ORG_X:   org_q[0]  <= pwdata;
        REG_ORG_Y:   org_q[1]  <= pwdata;
        REG_ORG_Z:   org_q[2]  <= pwdata;
        REG_DIR_X:   dir_q[0]  <= pwdata;
        REG_DIR_Y:   dir_q[1]  <= pwdata;
        REG_DIR_Z:   dir_q[2]  <= pwdata;
        REG_DET_EPS: det_eps_q <= pwdata;
        REG_HIT_EPS: hit_eps_q <= pwdata[W_EPS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORG_X:   prdata = org_q[0];
      REG_ORG_Y:   prdata = org_q[1];
      REG_ORG_Z:   prdata = org_q[2];
      REG_DIR_X:   prdata = dir_q[0];
      REG_DIR_Y:   prdata = dir_q[1];
      REG_DIR_Z:   prdata = dir_q[2];
      REG_DET_EPS: prdata = det_eps_q;
      REG_HIT_EPS: prdata = {{(W_DATA-W_EPS){1'b0}}, hit_eps_q};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // flow control: every stage moves unless the skid stage is occupied
  // --------------------------------------------------------------------------
  logic          adv;
  logic          skid_vld_q;
  logic [NS-1:0] vld_q;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: origin minus vertex, latch edges
  // --------------------------------------------------------------------------
  crd_t                    in_va [3];
  crd_t                    in_e1 [3];
  crd_t                    in_e2 [3];
  logic signed [W_TV-1:0]  s0_tv_q [3];
  crd_t                    s0_e1_q [3];
  crd_t                    s0_e2_q [3];

  assign in_va = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign in_e1 = '{edge_ab_x_i, edge_ab_y_i, edge_ab_z_i};
  assign in_e2 = '{edge_ac_x_i, edge_ac_y_i, edge_ac_z_i};

  // --------------------------------------------------------------------------
  // stage 1: products of the two cross products P = D x E2, Q = T x E1
  // stage 2: cross product differences
  // --------------------------------------------------------------------------
  logic signed [63:0]      s1_pp_q [3][2];
  logic signed [64:0]      s1_qp_q [3][2];
  logic signed [W_TV-1:0]  s1_tv_q [3];
  crd_t                    s1_e1_q [3];
  crd_t                    s1_e2_q [3];

  logic signed [W_XP-1:0]  s2_p_q  [3];
  logic signed [W_XP-1:0]  s2_q_q  [3];
  logic signed [W_TV-1:0]  s2_tv_q [3];
  crd_t                    s2_e1_q [3];
  crd_t                    s2_e2_q [3];

  // --------------------------------------------------------------------------
  // stage 3: partial products of the four dot products
  //   0: det = E1.P   1: u = T.P   2: v = D.Q   3: t = E2.Q
  // the wide operand splits into an unsigned low and a signed high half
  // --------------------------------------------------------------------------
  logic signed [W_TV-1:0]  ma [4][3];
  logic signed [W_XP-1:0]  mb [4][3];
  logic signed [66:0]      s3_lo_q [4][3];
  logic signed [65:0]      s3_hi_q [4][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ma[0][c] = W_TV'(s2_e1_q[c]);
      mb[0][c] = s2_p_q[c];
      ma[1][c] = s2_tv_q[c];
      mb[1][c] = s2_p_q[c];
      ma[2][c] = W_TV'(dir_q[c]);
      mb[2][c] = s2_q_q[c];
      ma[3][c] = W_TV'(s2_e2_q[c]);
      mb[3][c] = s2_q_q[c];
    end
  end

  // stage 4: recombine halves, stage 5: sum of three terms
  dot_t s4_term_q [4][3];
  dot_t s5_dot_q  [4];

  // --------------------------------------------------------------------------
  // stage 6: fold the sign of det into all four quantities
  // --------------------------------------------------------------------------
  dot_t s6_det_q, s6_un_q, s6_vn_q, s6_tn_q;

  // --------------------------------------------------------------------------
  // stage 7: barycentric, determinant and t range checks, partial products eps * det
  // --------------------------------------------------------------------------
  logic signed [W_DOT:0]   uv_sum;
  logic                    s7_ok_q;
  logic [W_EPS+33:0]       s7_ep_q [3];
  dot_t                    s7_det_q, s7_tn_q;

  assign uv_sum = {s6_un_q[W_DOT-1], s6_un_q} + {s6_vn_q[W_DOT-1], s6_vn_q};

  // stage 8: eps * det
  logic [WS-1:0]           s8_lo_q;
  logic                    s8_ok_q;
  dot_t                    s8_det_q, s8_tn_q;

  // stage 9: crossing must lie strictly inside the trimmed segment
  logic signed [WS-1:0]    ts_sc, hi_sc, lo_sc;
  logic                    s9_hit_q;
  logic [W_DOT-1:0]        s9_det_q, s9_rem_q;

  assign lo_sc = $signed(s8_lo_q);
  assign ts_sc = WS'(s8_tn_q) <<< FRACTION_BITS;
  assign hi_sc = (WS'(s8_det_q) <<< FRACTION_BITS) - lo_sc;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        // stage 0
        s0_tv_q[c] <= W_TV'(org_q[c]) - W_TV'(in_va[c]);
        s0_e1_q[c] <= in_e1[c];
        s0_e2_q[c] <= in_e2[c];
        // stage 1
        s1_pp_q[c][0] <= 64'(dir_q[(c == 2) ? 0 : c + 1]) *
                         64'(s0_e2_q[(c == 0) ? 2 : c - 1]);
        s1_pp_q[c][1] <= 64'(dir_q[(c == 0) ? 2 : c - 1]) *
                         64'(s0_e2_q[(c == 2) ? 0 : c + 1]);
        s1_qp_q[c][0] <= 65'(s0_tv_q[(c == 2) ? 0 : c + 1]) *
                         65'(s0_e1_q[(c == 0) ? 2 : c - 1]);
        s1_qp_q[c][1] <= 65'(s0_tv_q[(c == 0) ? 2 : c - 1]) *
                         65'(s0_e1_q[(c == 2) ? 0 : c + 1]);
        s1_tv_q[c] <= s0_tv_q[c];
        s1_e1_q[c] <= s0_e1_q[c];
        s1_e2_q[c] <= s0_e2_q[c];
        // stage 2
        s2_p_q[c]  <= W_XP'(s1_pp_q[c][0]) - W_XP'(s1_pp_q[c][1]);
        s2_q_q[c]  <= W_XP'(s1_qp_q[c][0]) - W_XP'(s1_qp_q[c][1]);
        s2_tv_q[c] <= s1_tv_q[c];
        s2_e1_q[c] <= s1_e1_q[c];
        s2_e2_q[c] <= s1_e2_q[c];
      end
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          // stage 3
          s3_lo_q[k][c] <= 67'(ma[k][c]) * $signed({34'd0, mb[k][c][32:0]});
          s3_hi_q[k][c] <= 66'(ma[k][c]) * 66'($signed(mb[k][c][W_XP-1:33]));
          // stage 4
          s4_term_q[k][c] <= (W_DOT'(s3_hi_q[k][c]) <<< 33) + W_DOT'(s3_lo_q[k][c]);
        end
        // stage 5
        s5_dot_q[k] <= s4_term_q[k][0] + s4_term_q[k][1] + s4_term_q[k][2];
      end
      // stage 6
      if (s5_dot_q[0][W_DOT-1]) begin
        s6_det_q <= -s5_dot_q[0];
        s6_un_q  <= -s5_dot_q[1];
        s6_vn_q  <= -s5_dot_q[2];
        s6_tn_q  <= -s5_dot_q[3];
      end else begin
        s6_det_q <= s5_dot_q[0];
        s6_un_q  <= s5_dot_q[1];
        s6_vn_q  <= s5_dot_q[2];
        s6_tn_q  <= s5_dot_q[3];
      end
      // stage 7
      s7_ok_q <= !(s6_det_q < $signed({{(W_DOT-32){1'b0}}, det_eps_q}))
              && !s6_un_q[W_DOT-1] && !(s6_det_q < s6_un_q)
              && !s6_vn_q[W_DOT-1] && !((W_DOT+1)'(s6_det_q) < uv_sum)
              && !s6_tn_q[W_DOT-1] && (s6_tn_q < s6_det_q);
      s7_ep_q[0] <= hit_eps_q * s6_det_q[33:0];
      s7_ep_q[1] <= hit_eps_q * s6_det_q[67:34];
      s7_ep_q[2] <= hit_eps_q * {2'b00, s6_det_q[W_DOT-1:68]};
      s7_det_q   <= s6_det_q;
      s7_tn_q    <= s6_tn_q;
      // stage 8
      s8_lo_q  <= WS'(s7_ep_q[0]) + (WS'(s7_ep_q[1]) << 34) + (WS'(s7_ep_q[2]) << 68);
      s8_ok_q  <= s7_ok_q;
      s8_det_q <= s7_det_q;
      s8_tn_q  <= s7_tn_q;
      // stage 9
      s9_hit_q <= s8_ok_q && (lo_sc < ts_sc) && (ts_sc < hi_sc);
      s9_det_q <= s8_det_q;
      s9_rem_q <= s8_tn_q;
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage: frac = floor(t * 2^F / det)
  // --------------------------------------------------------------------------
  logic [W_DOT-1:0]         dv_rem_q  [NDIV];
  logic [W_DOT-1:0]         dv_det_q  [NDIV];
  logic [FRACTION_BITS-1:0] dv_frac_q [NDIV];
  logic                     dv_hit_q  [NDIV];

  logic [W_DOT-1:0]         dv_rem_in  [NDIV];
  logic [W_DOT-1:0]         dv_det_in  [NDIV];
  logic [FRACTION_BITS-1:0] dv_frac_in [NDIV];
  logic                     dv_hit_in  [NDIV];
  logic [W_DOT-1:0]         dv_twice   [NDIV];
  logic                     dv_ge      [NDIV];

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      if (i == 0) begin
        dv_rem_in[i]  = s9_rem_q;
        dv_det_in[i]  = s9_det_q;
        dv_frac_in[i] = '0;
        dv_hit_in[i]  = s9_hit_q;
      end else begin
        dv_rem_in[i]  = dv_rem_q[i-1];
        dv_det_in[i]  = dv_det_q[i-1];
        dv_frac_in[i] = dv_frac_q[i-1];
        dv_hit_in[i]  = dv_hit_q[i-1];
      end
      dv_twice[i] = {dv_rem_in[i][W_DOT-2:0], 1'b0};
      dv_ge[i]    = dv_twice[i] >= dv_det_in[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NDIV; i++) begin
        dv_rem_q[i]  <= dv_ge[i] ? dv_twice[i] - dv_det_in[i] : dv_twice[i];
        dv_det_q[i]  <= dv_det_in[i];
        dv_frac_q[i] <= {dv_frac_in[i][FRACTION_BITS-2:0], dv_ge[i]};
        dv_hit_q[i]  <= dv_hit_in[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid stage
  // --------------------------------------------------------------------------
  logic [FRACTION_BITS+15:0] frac_ext;
  logic [15:0]               fin_frac;
  logic                      fin_hit;
  logic                      leave_vld;
  logic                      out_take;
  logic                      out_vld_q;
  logic                      out_hit_q, skid_hit_q;
  logic [15:0]               out_frac_q, skid_frac_q;

  assign frac_ext  = {16'd0, dv_frac_q[NDIV-1]};
  assign fin_hit   = dv_hit_q[NDIV-1];
  assign fin_frac  = fin_hit ? frac_ext[15:0] : 16'd0;
  assign leave_vld = vld_q[NS-1] && adv;
  assign out_take  = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q  <= skid_vld_q || leave_vld;
      skid_vld_q <= 1'b0;
    end else if (leave_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_hit_q  <= skid_vld_q ? skid_hit_q  : fin_hit;
      out_frac_q <= skid_vld_q ? skid_frac_q : fin_frac;
    end else if (leave_vld) begin
      skid_hit_q  <= fin_hit;
      skid_frac_q <= fin_frac;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign hit_o          = out_hit_q;
  assign hit_fraction_o = out_frac_q;

`ifndef SYNTHESIS
  // a miss always carries a zero fraction
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_fraction_o == 16'd0)
    else $error("miss with nonzero fraction");

  // input stalls only behind a full output register
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // skid stage fills whenever an item leaves while the output is held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_vld_q && leave_vld && out_vld_q && out_stall_i |=> skid_vld_q)
    else $error("item dropped at output");

  // divider remainder stays below the divisor for a hit
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && dv_hit_q[NDIV-1] |-> dv_rem_q[NDIV-1] < dv_det_q[NDIV-1])
    else $error("divider remainder out of range");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the segment/triangle intersection pipeline
// ----------------------------------------------------------------------------
// Drives triangle items against a segment held in the registers and checks
// each hit flag and crossing fraction against an exact wide-integer predictor
// or a typed-in answer. A directed table comes first, then random phases with
// random register settings, with random idling on both sides of the pipeline.
module tb;
  import sti_pkg::*;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 10 + FRAC;
  localparam int WD_LIMIT = 4000;
  localparam int N_RANDOM = 1750;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    crd_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] frac;
  } res_t;

  // one directed row: triangle, and a typed-in answer where obvious
  typedef struct packed {
    tri_t tgl;
    logic known;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [W_PADDR-1:0] paddr = '0;
  logic [W_DATA-1:0] pwdata = '0;
  logic [W_DATA-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  tri_t in_tri = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [15:0] hit_fraction;

  // predictor copy of the registers
  crd_t org[3], dir[3];
  logic [31:0] det_eps;
  logic [14:0] hit_eps;

  res_t expected_q[$];
  int errors = 0;
  int quiet = 0;
  bit idle_free = 1'b0;

  always #5 clk = ~clk;

  segment_triangle_intersect #(.FRACTION_BITS(FRAC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vert_a_x_i(in_tri.ax), .vert_a_y_i(in_tri.ay), .vert_a_z_i(in_tri.az),
    .edge_ab_x_i(in_tri.bx), .edge_ab_y_i(in_tri.by), .edge_ab_z_i(in_tri.bz),
    .edge_ac_x_i(in_tri.cx), .edge_ac_y_i(in_tri.cy), .edge_ac_z_i(in_tri.cz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_o(hit), .hit_fraction_o(hit_fraction)
  );

  // exact moller-trumbore test; triple products fit easily in 128 bits
  function automatic res_t predict(tri_t t);
    big_t a[3], e1[3], e2[3], tv[3], p[3], q[3], d[3];
    big_t det, un, vn, tn, one, eps, r;
    res_t res;
    res = '0;
    a = '{big_t'(t.ax), big_t'(t.ay), big_t'(t.az)};
    e1 = '{big_t'(t.bx), big_t'(t.by), big_t'(t.bz)};
    e2 = '{big_t'(t.cx), big_t'(t.cy), big_t'(t.cz)};
    for (int i = 0; i < 3; i++) begin
      d[i] = big_t'(dir[i]);
      tv[i] = big_t'(org[i]) - a[i];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = tv[1]*e1[2] - tv[2]*e1[1];
    q[1] = tv[2]*e1[0] - tv[0]*e1[2];
    q[2] = tv[0]*e1[1] - tv[1]*e1[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    un = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
    vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    one = big_t'(1) <<< FRAC;
    eps = big_t'({1'b0, hit_eps});
    // parallel, outside triangle, or too close to a segment end
    if (det < big_t'({1'b0, det_eps})) return res;
    if (un < 0 || un > det) return res;
    if (vn < 0 || un + vn > det) return res;
    if (!(eps*det < tn*one) || !(tn*one < (one - eps)*det)) return res;
    if (tn < 0 || tn >= det) return res;
    r = tn;
    for (int i = 0; i < FRAC; i++) begin
      r = r + r;
      res.frac = {res.frac[14:0], 1'b0};
      if (r >= det) begin
        r = r - det;
        res.frac[0] = 1'b1;
      end
    end
    res.hit = 1'b1;
    return res;
  endfunction

  // apb write, setup then access; pready is always high
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = W_PADDR'({idx, 2'b00}); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_ORG_X, REG_ORG_Y, REG_ORG_Z: org[idx] = val;
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: dir[idx - REG_DIR_X] = val;
      REG_DET_EPS: det_eps = val;
      default: hit_eps = val[14:0];
    endcase
  endtask

  task automatic set_segment(crd_t ox, crd_t oy, crd_t oz, crd_t dx, crd_t dy,
                             crd_t dz, logic [31:0] de, logic [14:0] he);
    write_reg(REG_ORG_X, ox); write_reg(REG_ORG_Y, oy); write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx); write_reg(REG_DIR_Y, dy); write_reg(REG_DIR_Z, dz);
    write_reg(REG_DET_EPS, de); write_reg(REG_HIT_EPS, {17'b0, he});
  endtask

  // present one item, hold it until accepted; valid stays up between items unless an idle cycle is inserted
  task automatic send_tri(tri_t t, logic known, res_t res);
    if (!idle_free && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_tri = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(known ? res : predict(t));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // random value with frequent extremes and small magnitudes
  function automatic crd_t rnd_crd();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return crd_t'($urandom);
      default: return crd_t'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
    endcase
  endfunction

  // triangle that the current segment mostly crosses, with random jitter
  function automatic tri_t aimed_tri();
    tri_t t;
    crd_t c[3];
    int unsigned s;
    s = $urandom_range(1, 8) << 16;
    for (int i = 0; i < 3; i++)
      c[i] = org[i] + (dir[i] >>> 1) + crd_t'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
    t.bx = crd_t'(s); t.by = crd_t'($signed($urandom_range(0, 2*s)) - $signed(s)); t.bz = '0;
    t.cx = '0; t.cy = crd_t'(s); t.cz = crd_t'($signed($urandom_range(0, s)) - $signed(s/2));
    if ($urandom_range(1)) begin
      t.bz = t.bx; t.bx = '0;
    end
    t.ax = c[0] - (t.bx >>> 2) - (t.cx >>> 2);
    t.ay = c[1] - (t.by >>> 2) - (t.cy >>> 2);
    t.az = c[2] - (t.bz >>> 2) - (t.cz >>> 2);
    return t;
  endfunction

  function automatic tri_t noise_tri();
    tri_t t;
    t = {rnd_crd(), rnd_crd(), rnd_crd(), rnd_crd(), rnd_crd(), rnd_crd(),
         rnd_crd(), rnd_crd(), rnd_crd()};
    return t;
  endfunction

  // result side: random stalls, check against the oldest expectation
  always @(negedge clk) begin
    if (rst_n)
      out_stall <= !idle_free && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b frac=%h", $time, hit, hit_fraction);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (hit !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
          errors++;
        end
        if (hit_fraction !== exp_r.frac) begin
          $display("%0t: hit_fraction expected %h actual %h", $time, exp_r.frac,
                   hit_fraction);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WD_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // directed table
  localparam crd_t ONE = 32'sh10000;
  row_t table_rows[$];

  initial begin
    res_t miss;
    miss = '0;
    org = '{0, 0, 0}; dir = '{0, 0, 0};
    det_eps = 32'd1; hit_eps = 15'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // after reset the direction is zero, so every determinant is zero
    table_rows.push_back('{'{ONE, ONE, ONE, ONE, 0, 0, 0, ONE, 0}, 1'b1, miss});
    table_rows.push_back('{'{32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff,
                             32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                             32'sh7fffffff, 32'sh80000000}, 1'b1, miss});
    foreach (table_rows[i]) send_tri(table_rows[i].tgl, table_rows[i].known,
                                     table_rows[i].res);
    drain();

    // segment along z from z = -1 to z = +1, triangles in the xy plane
    set_segment(0, 0, -ONE, 0, 0, 2*ONE, 32'd1, 15'd1);
    table_rows.delete();
    table_rows.push_back('{'{-ONE, -ONE, 0, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b0, miss});
    table_rows.push_back('{'{-ONE, -ONE, 0, 0, 4*ONE, 0, 4*ONE, 0, 0}, 1'b0, miss});
    // vertex and edge exactly on the segment count as inside
    table_rows.push_back('{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b0, miss});
    table_rows.push_back('{'{-ONE, 0, 0, 2*ONE, 0, 0, 0, ONE, 0}, 1'b0, miss});
    // outside: u < 0, v < 0, u + v > 1
    table_rows.push_back('{'{ONE, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1, miss});
    table_rows.push_back('{'{0, ONE, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1, miss});
    table_rows.push_back('{'{-3*ONE, -3*ONE, 0, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b1, miss});
    // crossing at either segment end or beyond it
    table_rows.push_back('{'{-ONE, -ONE, -ONE, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b1, miss});
    table_rows.push_back('{'{-ONE, -ONE, ONE, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b1, miss});
    table_rows.push_back('{'{-ONE, -ONE, 3*ONE, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b1, miss});
    // parallel triangle, edges in the xz plane containing the direction
    table_rows.push_back('{'{-ONE, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b1, miss});
    // degenerate triangle
    table_rows.push_back('{'{-ONE, -ONE, 0, 0, 0, 0, 0, 0, 0}, 1'b1, miss});
    table_rows.push_back('{'{-ONE, -ONE, 32'sh4000, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b0, miss});
    table_rows.push_back('{'{-ONE, -ONE, 32'sh7fffffff, 32'sh7fffffff, 0, 0,
                             0, 32'sh80000000, 0}, 1'b0, miss});
    foreach (table_rows[i]) send_tri(table_rows[i].tgl, table_rows[i].known,
                                     table_rows[i].res);
    drain();

    // extreme registers: huge det epsilon, hit epsilon just under half
    set_segment(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'hffffffff, 15'h7fff);
    for (int i = 0; i < 6; i++) send_tri(i < 3 ? aimed_tri() : noise_tri(), 1'b0, miss);
    drain();
    // zero epsilons: a zero determinant still fails the interval tests
    set_segment(0, 0, -ONE, 0, 0, 2*ONE, 32'd0, 15'd0);
    send_tri('{-ONE, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b1, miss);
    send_tri('{-ONE, -ONE, 0, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b0, miss);
    send_tri('{-ONE, -ONE, -ONE, 4*ONE, 0, 0, 0, 4*ONE, 0}, 1'b0, miss);
    drain();

    // random phases, each with its own segment and thresholds
    for (int ph = 0; ph < 14; ph++) begin
      logic [31:0] de;
      logic [14:0] he;
      de = ph % 4 == 0 ? $urandom : $urandom_range(0, 16);
      he = ph % 5 == 0 ? 15'($urandom) : 15'($urandom_range(0, 4096));
      set_segment(rnd_crd(), rnd_crd(), rnd_crd(),
                  crd_t'($signed($urandom_range(0, 32'h80000)) - 32'sh40000),
                  crd_t'($signed($urandom_range(0, 32'h80000)) - 32'sh40000),
                  ph % 3 == 0 ? rnd_crd() : crd_t'($urandom_range(1, 32'h80000)),
                  de, he);
      // a stretch with no idling at all in the middle of the run
      idle_free = (ph == 7);
      for (int i = 0; i < N_RANDOM / 14; i++)
        send_tri($urandom_range(99) < 75 ? aimed_tri() : noise_tri(), 1'b0, miss);
      drain();
    end
    idle_free = 1'b0;

    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/sti_pkg.sv
src/segment_triangle_intersect.sv
tb/tb.sv
